### design/assert_macros.svh
// assertion shorthands shared by the speed meter modules
// clock and reset are the block's i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ESM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("speed meter assertion failed");

// condition implies a consequence in the following cycle
`define ESM_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("speed meter assertion failed");

`endif

### design/esm_pkg.sv
// ---------------------------------------------------------------------------
// esm_pkg
// Types and constants of the encoder speed meter: beat payloads, register
// indexes, commands, controller states and divider sizing.
// ---------------------------------------------------------------------------
package esm_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    // |delta| * 60000 < 2^47, pulses_per_rev * elapsed < 2^48
    localparam int NUM_W     = 47;
    localparam int DEN_W     = 48;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_PPR    = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_cmd        cmd;
        logic        b_level;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic signed [31:0] rpm;
        logic signed [31:0] last_delta;
        logic signed [31:0] total_count;
        logic               rpm_updated;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic div_step;
        logic sat;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_ctrl_sts;

endpackage

### design/esm_ctrl.sv
// ---------------------------------------------------------------------------
// esm_ctrl
// Sequencer of the speed meter: takes one beat at a time, steps the
// datapath through update, then multiply, divide and saturate when a speed is due, and result load.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module esm_ctrl
    import esm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    // state and iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_div ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = DIV_CNT_W'(DIV_STEPS - 1);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ESM_ASSERT(a_cmd_onehot, $onehot0(o_cmd))
    `ESM_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == ST_EXEC)
    `ESM_ASSERT(a_cnt_range, r_state != ST_DIV || r_cnt < DIV_CNT_W'(DIV_STEPS))

endmodule

### design/esm_dp.sv
// ---------------------------------------------------------------------------
// esm_dp
// Datapath of the speed meter: configuration, edge counters, sample
// bookkeeping, multiply stage, restoring divider, saturation and the
// output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module esm_dp
    import esm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in                  i_in,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out                 o_out,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_sts            o_sts
);

    // configuration
    logic             r_enable;
    logic [CFG_W-1:0] r_ppr;
    logic [CFG_W-1:0] r_period;

    // item and counter state
    t_in               r_in;
    logic [DATA_W-1:0] r_total;
    logic [DATA_W-1:0] r_window;
    logic [DATA_W-1:0] r_delta;
    logic [DATA_W-1:0] r_speed;
    logic [DATA_W-1:0] r_last_time;
    logic [DATA_W-1:0] r_elapsed;
    logic              r_updated;

    // divider
    logic             r_neg;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;

    // output register
    logic r_out_valid;
    t_out r_out;

    logic [DATA_W-1:0] elapsed;
    logic              take;
    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] delta_mag;
    logic [DEN_W-1:0]  num_full;
    logic [DEN_W-1:0]  den_full;
    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic [DATA_W-1:0] sat_val;

    // sample decision on the current state
    assign elapsed = r_in.now_ms - r_last_time;
    assign take    = (r_in.cmd == CMD_SAMPLE) && r_enable && (r_last_time != '0)
                     && (elapsed >= {16'b0, r_period});
    assign step    = r_in.b_level ? {DATA_W{1'b1}} : DATA_W'(1);

    assign o_sts.need_div = take && (r_ppr != '0) && (elapsed != '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // magnitudes for the divide
    assign delta_mag = r_delta[DATA_W-1] ? (~r_delta + 1'b1) : r_delta;
    assign num_full  = {16'b0, delta_mag} * {32'b0, MS_PER_MIN};
    assign den_full  = {32'b0, r_ppr} * {16'b0, r_elapsed};

    // one restoring divide step
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, r_den};

    // saturate quotient magnitude to signed 32 bits
    always_comb begin
        if (r_neg) begin
            if (r_quo > NUM_W'(64'h8000_0000)) begin
                sat_val = 32'h8000_0000;
            end else begin
                sat_val = ~r_quo[DATA_W-1:0] + 1'b1;
            end
        end else begin
            if (r_quo > NUM_W'(64'h7FFF_FFFF)) begin
                sat_val = 32'h7FFF_FFFF;
            end else begin
                sat_val = r_quo[DATA_W-1:0];
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_ppr    <= 16'd1024;
            r_period <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_PPR:    r_ppr    <= i_cfg_data;
                CFG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
    end

    // counters, sample bookkeeping and speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_window    <= '0;
            r_delta     <= '0;
            r_speed     <= '0;
            r_last_time <= '0;
            r_updated   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_updated <= take;
            unique case (r_in.cmd)
                CMD_EDGE: begin
                    r_total  <= r_total + step;
                    r_window <= r_window + step;
                end
                CMD_SAMPLE: begin
                    if (r_enable && r_last_time == '0) begin
                        r_last_time <= r_in.now_ms;
                    end else if (take) begin
                        r_delta     <= r_window;
                        r_window    <= '0;
                        r_last_time <= r_in.now_ms;
                        if (!o_sts.need_div) begin
                            r_speed <= '0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    r_total     <= '0;
                    r_window    <= '0;
                    r_delta     <= '0;
                    r_speed     <= '0;
                    r_last_time <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.sat) begin
            r_speed <= sat_val;
        end
    end

    // elapsed time of a taken window
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_elapsed <= elapsed;
        end
    end

    // multiply stage loads the divider, then one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_neg <= r_delta[DATA_W-1];
            r_den <= den_full;
            r_quo <= num_full[NUM_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], ~diff[DEN_W+1]};
            r_rem <= diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.rpm         <= r_speed;
            r_out.last_delta  <= r_delta;
            r_out.total_count <= r_total;
            r_out.rpm_updated <= r_updated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ESM_ASSERT(a_load_free, !i_cmd.out_load || !r_out_valid || i_out_ready)
    `ESM_ASSERT_NEXT(a_window_cleared, i_cmd.exec && take, r_window == '0 && r_updated)

endmodule

### design/encoder_speed_meter.sv
// ---------------------------------------------------------------------------
// encoder_speed_meter
// Encoder edge counter and speed meter. Input beats carry an A-phase edge,
// a timed sample or a clear; every beat yields one result beat.
//
// Usage:
//  - input channel i_in_valid / o_in_ready with payload i_in (cmd, b_level,
//    now_ms); output channel o_out_valid / i_out_ready with payload o_out
//  - configuration by i_cfg_we, i_cfg_idx, i_cfg_data while no beat is in
//    flight: 0 enable, 1 pulses per revolution, 2 sample period in ms
//  - an edge, clear or sample that takes no window goes through update and
//    result load; a sample that computes speed also passes the multiply, the
//    47-step restoring divider (one quotient bit per cycle) and saturation
//  - one beat at a time: the next beat can be taken in the cycle after the
//    result is loaded, not while the last beat is still in the sequence
//  - the result sits in an output register; the next beat is accepted while
//    it waits, and only loading the following result waits for the receiver
//  - reset clears all counts, speed and sample time, disables sampling and
//    sets 1024 pulses per revolution and a 100 ms period
// ---------------------------------------------------------------------------
module encoder_speed_meter
    import esm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out
);

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    // sequencer
    esm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (ctrl_sts),
        .o_cmd      (ctrl_cmd)
    );

    // datapath
    esm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (ctrl_cmd),
        .o_sts       (ctrl_sts)
    );

endmodule

### test/tb_encoder_speed_meter.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_encoder_speed_meter
// Self-checking bench for the encoder speed meter. A queue-fed driver offers
// edge, sample, clear and unused-command beats in random bursts; a monitor
// scores every result beat against a cycle-free model of the counters and
// the speed divide. Runs go through several register settings, including
// zero divisors and elapsed times that wrap.
// ---------------------------------------------------------------------------
module tb_encoder_speed_meter;
    import esm_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BEATS   = 100;
    localparam int MAX_PRINTED   = 40;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    t_cfg_idx         cfg_idx = CFG_ENABLE;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in              in_beat = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_beat;

    // model copy of the registers and counters, at reset values
    logic        en_cfg = 1'b0;
    logic [15:0] ppr_cfg = 16'd1024;
    logic [15:0] period_cfg = 16'd100;
    logic [31:0] edge_total = '0;
    logic [31:0] edge_window = '0;
    logic [31:0] window_taken = '0;
    logic [31:0] speed_now = '0;
    logic [31:0] sample_stamp = '0;

    t_in  beats_to_send[$];
    t_out readings_due[$];

    int mismatches = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int burst_left = 1;
    int gap_left = 0;
    int run_left = 0;
    int hold_left = 0;

    encoder_speed_meter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // advance the counter model by one beat and form its reading
    task automatic meter_step(input t_in beat, output t_out reading);
        logic [31:0] elapsed;
        longint      num;
        longint      den;
        longint      quot;
        reading = '0;
        elapsed = beat.now_ms - sample_stamp;
        case (beat.cmd)
            CMD_EDGE: begin
                edge_total  = edge_total + (beat.b_level ? 32'hFFFF_FFFF : 32'd1);
                edge_window = edge_window + (beat.b_level ? 32'hFFFF_FFFF : 32'd1);
            end
            CMD_SAMPLE: begin
                if (en_cfg) begin
                    if (sample_stamp == 32'd0) begin
                        // first sample only records the time
                        sample_stamp = beat.now_ms;
                    end else if (elapsed >= {16'd0, period_cfg}) begin
                        window_taken = edge_window;
                        edge_window  = '0;
                        sample_stamp = beat.now_ms;
                        reading.rpm_updated = 1'b1;
                        if (ppr_cfg == 16'd0 || elapsed == 32'd0) begin
                            speed_now = '0;
                        end else begin
                            num  = longint'($signed(window_taken)) * 64'sd60000;
                            den  = longint'({48'd0, ppr_cfg}) * longint'({32'd0, elapsed});
                            quot = num / den;
                            if (quot > 64'sd2147483647) begin
                                quot = 64'sd2147483647;
                            end else if (quot < -64'sd2147483648) begin
                                quot = -64'sd2147483648;
                            end
                            speed_now = quot[31:0];
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                edge_total   = '0;
                edge_window  = '0;
                window_taken = '0;
                speed_now    = '0;
                sample_stamp = '0;
            end
            default: begin
            end
        endcase
        reading.rpm         = speed_now;
        reading.last_delta  = window_taken;
        reading.total_count = edge_total;
    endtask

    task automatic flag_mismatch(string what);
        if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0d expected %0d", field,
                                    $signed(got), $signed(want)));
        end
    endtask

    function automatic void queue_beat(t_cmd cmd, logic b_level, logic [31:0] now_ms);
        t_in beat;
        beat.cmd     = cmd;
        beat.b_level = b_level;
        beat.now_ms  = now_ms;
        beats_to_send.push_back(beat);
    endfunction

    // register write, then update the model copy; block is idle here
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE: en_cfg = value[0];
            CFG_PPR:    ppr_cfg = value;
            CFG_PERIOD: period_cfg = value;
            default: begin
            end
        endcase
        @(negedge clk);
    endtask

    // wait until every queued beat is taken and every reading has come back
    task automatic wait_drained();
        do @(negedge clk);
        while (beats_to_send.size() != 0 || in_valid || readings_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // input driver: bursts of beats with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (beats_to_send.size() != 0) begin
                in_valid <= 1'b1;
                in_beat  <= beats_to_send.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                              : $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: own stall pattern plus requested long hold-offs
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else if (out_ready) begin
            out_ready <= 1'b0;
            run_left  <= $urandom_range(0, 4);
        end else begin
            out_ready <= 1'b1;
            run_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
        end
    end

    // score the result beat, then predict the input beat taken at this edge
    always @(posedge clk) begin : monitor
        t_out want;
        t_out fresh;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (readings_due.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    want = readings_due.pop_front();
                    check_field("rpm", out_beat.rpm, want.rpm);
                    check_field("last_delta", out_beat.last_delta, want.last_delta);
                    check_field("total_count", out_beat.total_count, want.total_count);
                    check_field("rpm_updated", {31'd0, out_beat.rpm_updated},
                                {31'd0, want.rpm_updated});
                end
            end
            if (in_valid && in_ready) begin
                meter_step(in_beat, fresh);
                readings_due.push_back(fresh);
            end
        end
    end

    // run limit
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("encoder_speed_meter verification failed");
        $finish;
    end

    // stimulus sequence
    initial begin : sequencer
        int unsigned t_now;
        int unsigned adv;
        int          sel;
        int          bias;
        int          k;
        int          p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disabled after reset: samples ignored, edges and clears still act
        queue_beat(CMD_SAMPLE, 1'b0, 32'd500);
        queue_beat(CMD_EDGE, 1'b0, 32'hFFFF_FFFF);
        queue_beat(CMD_EDGE, 1'b1, 32'd0);
        queue_beat(CMD_NOP, 1'b1, 32'd0);
        queue_beat(CMD_CLEAR, 1'b0, 32'd0);
        wait_drained();

        write_reg(CFG_ENABLE, 16'h0001);
        write_reg(CFG_PPR, 16'd1024);
        write_reg(CFG_PERIOD, 16'd100);
        // time zero keeps it unstarted, then record, short and full periods
        queue_beat(CMD_SAMPLE, 1'b0, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'd1000);
        queue_beat(CMD_EDGE, 1'b0, 32'd0);
        queue_beat(CMD_EDGE, 1'b0, 32'd0);
        queue_beat(CMD_EDGE, 1'b0, 32'd0);
        queue_beat(CMD_EDGE, 1'b1, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'd1099);
        queue_beat(CMD_SAMPLE, 1'b1, 32'd1100);
        queue_beat(CMD_EDGE, 1'b1, 32'd0);
        queue_beat(CMD_EDGE, 1'b1, 32'd0);
        queue_beat(CMD_EDGE, 1'b1, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'd1200);
        // elapsed time wrapping past 2^32
        queue_beat(CMD_CLEAR, 1'b1, 32'hFFFF_FFFF);
        queue_beat(CMD_SAMPLE, 1'b0, 32'hFFFF_FFF0);
        queue_beat(CMD_EDGE, 1'b0, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'h0000_0060);
        queue_beat(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF);
        queue_beat(CMD_NOP, 1'b0, 32'hFFFF_FFFF);
        wait_drained();

        // zero divisor: no pulses per rev, and zero elapsed with zero period
        write_reg(CFG_PPR, 16'd0);
        write_reg(CFG_PERIOD, 16'd0);
        queue_beat(CMD_EDGE, 1'b0, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF);
        queue_beat(CMD_EDGE, 1'b0, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'd5);
        wait_drained();

        write_reg(CFG_PPR, 16'hFFFF);
        write_reg(CFG_PERIOD, 16'hFFFF);
        queue_beat(CMD_EDGE, 1'b1, 32'd0);
        queue_beat(CMD_SAMPLE, 1'b0, 32'd5 + 32'd65534);
        queue_beat(CMD_SAMPLE, 1'b0, 32'd5 + 32'd65535);
        wait_drained();

        // random phases, each under its own register setting
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_ENABLE, {15'($urandom), 1'b1});
                    write_reg(CFG_PPR, 16'd1);
                    write_reg(CFG_PERIOD, 16'd1);
                end
                1: begin
                    write_reg(CFG_PPR, 16'hFFFF);
                    write_reg(CFG_PERIOD, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_ENABLE, {15'($urandom), 1'b0});
                    write_reg(CFG_PPR, 16'($urandom));
                    write_reg(CFG_PERIOD, 16'($urandom_range(0, 200)));
                    write_reg(CFG_UNUSED, 16'($urandom));
                end
                3: begin
                    write_reg(CFG_ENABLE, {15'($urandom), 1'b1});
                    write_reg(CFG_PPR, 16'd0);
                    write_reg(CFG_PERIOD, 16'($urandom_range(0, 200)));
                end
                4: begin
                    write_reg(CFG_PPR, 16'($urandom_range(1, 4096)));
                    write_reg(CFG_PERIOD, 16'($urandom_range(1, 1000)));
                end
                default: begin
                    write_reg(CFG_PPR, 16'($urandom));
                    write_reg(CFG_PERIOD, 16'd0);
                end
            endcase

            t_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                                : $urandom;
            bias = $urandom_range(10, 90);
            // long receiver hold-off while beats keep coming
            if (p == 1) hold_reqs++;
            for (k = 0; k < PHASE_BEATS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    queue_beat(CMD_EDGE, $urandom_range(0, 99) < bias, $urandom);
                end else if (sel < 84) begin
                    // time advances around the sample period
                    case ($urandom_range(0, 4))
                        0:       adv = $urandom_range(0, period_cfg);
                        1:       adv = $urandom_range(0, 3 * period_cfg + 5);
                        default: adv = period_cfg + $urandom_range(0, 20);
                    endcase
                    t_now = t_now + adv;
                    queue_beat(CMD_SAMPLE, 1'($urandom), t_now);
                end else if (sel < 88) begin
                    queue_beat(CMD_SAMPLE, 1'($urandom), $urandom);
                end else if (sel < 90) begin
                    queue_beat(CMD_SAMPLE, 1'($urandom), 32'd0);
                end else if (sel < 95) begin
                    queue_beat(CMD_CLEAR, 1'($urandom), $urandom);
                end else begin
                    queue_beat(CMD_NOP, 1'($urandom), $urandom);
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("encoder_speed_meter verification clean");
        end else begin
            $display("encoder_speed_meter verification failed");
        end
        $finish;
    end

endmodule

### encoder_speed_meter.f
+incdir+design
design/esm_pkg.sv
design/esm_ctrl.sv
design/esm_dp.sv
design/encoder_speed_meter.sv
test/tb_encoder_speed_meter.sv
